@@ sv/cmis_pkg.sv @@
`timescale 1ns / 1ps

package cmis_pkg;

    localparam logic [31:0] ALL_DOLLAR = 32'h2424_2424;
    localparam logic [7:0]  CH_DOLLAR  = 8'h24;
    localparam logic [7:0]  CH_NEWLINE = 8'h0A;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_ZERO    = 8'd48;
    localparam logic [7:0]  CH_NINE    = 8'd57;
    localparam logic [7:0]  CH_G       = 8'h47;
    localparam logic [7:0]  CH_D       = 8'h44;
    localparam logic [7:0]  CH_P       = 8'h50;
    localparam logic [7:0]  CH_H       = 8'h48;
    localparam logic [7:0]  CH_L       = 8'h4C;
    localparam logic [7:0]  CH_R       = 8'h52;
    localparam logic [7:0]  CH_S       = 8'h53;
    localparam logic [7:0]  CH_C       = 8'h43;
    localparam logic [7:0]  CH_B       = 8'h42;
    localparam logic [7:0]  CH_T       = 8'h54;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_CLEAR = 3'd1,
        OP_START = 3'd2,
        OP_EXEC  = 3'd3,
        OP_CARD  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_CARD    = 3'd1,
        ST_OUT     = 3'd2,
        ST_HALT    = 3'd3,
        ST_BADOP   = 3'd4,
        ST_BADADDR = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        K_GD,
        K_PD,
        K_LR,
        K_SR,
        K_CR,
        K_BT,
        K_H,
        K_BAD
    } kind_t;

    // Memory address source.
    typedef enum logic [2:0] {
        ASEL_IN,
        ASEL_IC,
        ASEL_PTR,
        ASEL_DEC,
        ASEL_LOC_NEXT
    } asel_t;

    typedef enum logic [1:0] {
        WSEL_IN,
        WSEL_GR,
        WSEL_MERGE
    } wsel_t;

    typedef enum logic [1:0] {
        RA_ZERO,
        RA_PTR,
        RA_DEC,
        RA_LOC_K
    } rasel_t;

    typedef struct packed {
        logic    load_in;
        logic    rd_en;
        logic    wr_en;
        asel_t   asel;
        wsel_t   wsel;
        logic    clear_job;
        logic    start_prog;
        logic    ic_inc;
        logic    ic_jump;
        logic    set_halt;
        logic    load_loc;
        logic    load_gr;
        logic    compare;
        logic    card_setup;
        logic    card_advance;
        logic    card_cancel;
        logic    k_clear;
        logic    k_inc;
        logic    emit;
        status_t res_status;
        rasel_t  res_asel;
        logic    res_word;
        logic    res_last;
    } dp_cmd_t;

    typedef struct packed {
        op_t   in_op;
        logic  addr_ok;
        logic  card_ok;
        logic  halted;
        logic  card_pending;
        logic  ic_oob;
        logic  rem_one;
        kind_t kind;
        logic  addr_err;
        logic  flag;
        logic  k_last;
    } dp_status_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
    } fmt_t;

    // Characters before the first dollar sign, newline shown as space.
    function automatic fmt_t format_word(input logic [31:0] w);
        fmt_t       r;
        logic       stop;
        logic [7:0] ch;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 4; i++) begin
            ch = w[8*i +: 8];
            if (ch == CH_DOLLAR) begin
                stop = 1'b1;
            end
            if (!stop) begin
                r.word[8*i +: 8] = (ch == CH_NEWLINE) ? CH_SPACE : ch;
                r.nbytes         = r.nbytes + 3'd1;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] card_mask(input logic [2:0] count);
        logic [31:0] m;
        logic [2:0]  n;
        m = '0;
        n = (count > 3'd4) ? 3'd4 : count;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < n) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

@@ sv/cmis_dp.sv @@
`timescale 1ns / 1ps

module cmis_dp #(
    parameter int MEM_WORDS   = 100,
    parameter int BLOCK_WORDS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [2:0]          op,
    input  logic [6:0]          address,
    input  logic [31:0]         word_data,
    input  logic [2:0]          byte_count,
    input  cmis_pkg::dp_cmd_t    cmd,
    output cmis_pkg::dp_status_t stat,
    output logic                done,
    output logic [2:0]          status,
    output logic [6:0]          out_address,
    output logic [31:0]         out_word,
    output logic [2:0]          out_bytes,
    output logic                last
);
    import cmis_pkg::*;

    localparam int AW = $clog2(MEM_WORDS);
    localparam int KW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;

    // Captured input word.
    op_t         in_op_reg;
    logic [6:0]  in_addr_reg;
    logic [31:0] in_data_reg;
    logic [2:0]  in_count_reg;

    // Machine state.
    logic [6:0]  ic_reg;
    logic [31:0] gr_reg;
    logic        flag_reg;
    logic [6:0]  ptr_reg;
    logic [3:0]  rem_reg;
    logic        halted_reg;
    logic [6:0]  loc_reg;
    logic [KW-1:0] k_reg;

    // Memory; a word never written since reset or clear reads as all dollar signs.
    logic [31:0] mem_reg [MEM_WORDS];
    logic        valid_reg [MEM_WORDS];
    logic [31:0] rd_word_reg;
    logic        rd_valid_reg;
    logic [31:0] rdata;

    logic          done_reg;
    status_t       status_reg;
    logic [6:0]    out_addr_reg;
    logic [31:0]   out_word_reg;
    logic [2:0]    out_bytes_reg;
    logic          last_reg;

    logic [7:0]  c0, c1, d0, d1;
    logic        digits_ok, loc_ok, is_block;
    logic [6:0]  dec_loc;
    logic [7:0]  dec_end;
    kind_t       kind;
    logic [6:0]  acc_addr;
    logic [AW-1:0] idx;
    logic [31:0] wdata;
    logic [31:0] mask;
    fmt_t        fmt;
    logic [6:0]  res_addr;

    assign rdata = rd_valid_reg ? rd_word_reg : ALL_DOLLAR;

    // Instruction decode straight off the read data.
    always_comb
    begin
        c0 = rdata[7:0];
        c1 = rdata[15:8];
        d0 = rdata[23:16];
        d1 = rdata[31:24];
        if (c0 == CH_H) begin
            kind = K_H;
        end else if (c0 == CH_G && c1 == CH_D) begin
            kind = K_GD;
        end else if (c0 == CH_P && c1 == CH_D) begin
            kind = K_PD;
        end else if (c0 == CH_L && c1 == CH_R) begin
            kind = K_LR;
        end else if (c0 == CH_S && c1 == CH_R) begin
            kind = K_SR;
        end else if (c0 == CH_C && c1 == CH_R) begin
            kind = K_CR;
        end else if (c0 == CH_B && c1 == CH_T) begin
            kind = K_BT;
        end else begin
            kind = K_BAD;
        end
        digits_ok = (d0 >= CH_ZERO) && (d0 <= CH_NINE) && (d1 >= CH_ZERO) && (d1 <= CH_NINE);
        // A digit's value is its low nibble; times ten is times eight plus times two.
        dec_loc  = {d0[3:0], 3'b000} + {2'b00, d0[3:0], 1'b0} + {3'b000, d1[3:0]};
        dec_end  = {1'b0, dec_loc} + 8'(BLOCK_WORDS);
        is_block = (c1 == CH_D);
        loc_ok   = (dec_loc < 7'(MEM_WORDS)) && (!is_block || dec_end <= 8'(MEM_WORDS));
    end

    always_comb
    begin
        case (cmd.asel)
            ASEL_IN:       acc_addr = in_addr_reg;
            ASEL_IC:       acc_addr = ic_reg;
            ASEL_PTR:      acc_addr = ptr_reg;
            ASEL_DEC:      acc_addr = dec_loc;
            ASEL_LOC_NEXT: acc_addr = loc_reg + 7'(k_reg) + 7'd1;
            default:       acc_addr = in_addr_reg;
        endcase
        idx  = acc_addr[AW-1:0];
        mask = card_mask(in_count_reg);
        case (cmd.wsel)
            WSEL_IN:    wdata = in_data_reg;
            WSEL_GR:    wdata = gr_reg;
            WSEL_MERGE: wdata = (rdata & ~mask) | (in_data_reg & mask);
            default:    wdata = in_data_reg;
        endcase
        case (cmd.res_asel)
            RA_ZERO:  res_addr = 7'd0;
            RA_PTR:   res_addr = ptr_reg;
            RA_DEC:   res_addr = dec_loc;
            RA_LOC_K: res_addr = loc_reg + 7'(k_reg);
            default:  res_addr = 7'd0;
        endcase
        fmt = format_word(rdata);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en) begin
            mem_reg[idx] <= wdata;
        end
        if (cmd.rd_en) begin
            rd_word_reg  <= mem_reg[idx];
            rd_valid_reg <= valid_reg[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < MEM_WORDS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (cmd.clear_job) begin
            for (int i = 0; i < MEM_WORDS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (cmd.wr_en) begin
            valid_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in) begin
            in_op_reg    <= op_t'(op);
            in_addr_reg  <= address;
            in_data_reg  <= word_data;
            in_count_reg <= byte_count;
        end
        if (cmd.load_loc) begin
            loc_reg <= dec_loc;
        end
        if (cmd.emit) begin
            status_reg    <= cmd.res_status;
            out_addr_reg  <= res_addr;
            out_word_reg  <= cmd.res_word ? fmt.word : 32'd0;
            out_bytes_reg <= cmd.res_word ? fmt.nbytes : 3'd0;
            last_reg      <= cmd.res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ic_reg     <= '0;
            gr_reg     <= ALL_DOLLAR;
            flag_reg   <= 1'b0;
            ptr_reg    <= '0;
            rem_reg    <= '0;
            halted_reg <= 1'b0;
            k_reg      <= '0;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= cmd.emit;
            if (cmd.clear_job) begin
                gr_reg   <= ALL_DOLLAR;
                flag_reg <= 1'b0;
                ptr_reg  <= '0;
            end else begin
                if (cmd.load_gr) begin
                    gr_reg <= rdata;
                end
                if (cmd.compare) begin
                    flag_reg <= (gr_reg == rdata);
                end
                if (cmd.card_setup) begin
                    ptr_reg <= dec_loc;
                end else if (cmd.card_advance) begin
                    ptr_reg <= ptr_reg + 7'd1;
                end
            end
            if (cmd.clear_job || cmd.start_prog) begin
                ic_reg <= '0;
            end else if (cmd.ic_jump) begin
                ic_reg <= dec_loc;
            end else if (cmd.ic_inc) begin
                ic_reg <= ic_reg + 7'd1;
            end
            if (cmd.clear_job || cmd.start_prog || cmd.card_cancel) begin
                rem_reg <= '0;
            end else if (cmd.card_setup) begin
                rem_reg <= 4'(BLOCK_WORDS);
            end else if (cmd.card_advance) begin
                rem_reg <= rem_reg - 4'd1;
            end
            if (cmd.clear_job || cmd.start_prog) begin
                halted_reg <= 1'b0;
            end else if (cmd.set_halt) begin
                halted_reg <= 1'b1;
            end
            if (cmd.k_clear) begin
                k_reg <= '0;
            end else if (cmd.k_inc) begin
                k_reg <= k_reg + KW'(1);
            end
        end
    end

    always_comb
    begin
        stat.in_op        = in_op_reg;
        stat.addr_ok      = in_addr_reg < 7'(MEM_WORDS);
        stat.card_ok      = (rem_reg != 4'd0) && (ptr_reg < 7'(MEM_WORDS));
        stat.halted       = halted_reg;
        stat.card_pending = rem_reg != 4'd0;
        stat.ic_oob       = ic_reg >= 7'(MEM_WORDS);
        stat.rem_one      = rem_reg == 4'd1;
        stat.kind         = kind;
        stat.addr_err     = !digits_ok || !loc_ok;
        stat.flag         = flag_reg;
        stat.k_last       = k_reg == KW'(BLOCK_WORDS - 1);
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign out_address = out_addr_reg;
    assign out_word    = out_word_reg;
    assign out_bytes   = out_bytes_reg;
    assign last        = last_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 4'(BLOCK_WORDS))
        else $error("card word count above block size");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> acc_addr < 7'(MEM_WORDS))
        else $error("memory write outside memory");

    a_halt_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(halted_reg) |-> $past(cmd.set_halt))
        else $error("halt set without a halt command");

endmodule

@@ sv/cmis_ctrl.sv @@
`timescale 1ns / 1ps

module cmis_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmis_pkg::dp_status_t stat,
    output cmis_pkg::dp_cmd_t    cmd
);
    import cmis_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_CARD_WR,
        S_DECODE,
        S_LOAD,
        S_COMPARE,
        S_PD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next   = S_IDLE;
                cmd.emit     = 1'b1;
                cmd.res_last = 1'b1;
                case (stat.in_op)
                    OP_WRITE:
                    begin
                        if (stat.addr_ok) begin
                            cmd.wr_en = 1'b1;
                            cmd.asel  = ASEL_IN;
                            cmd.wsel  = WSEL_IN;
                        end else begin
                            cmd.res_status = ST_BADADDR;
                        end
                    end
                    OP_CLEAR: cmd.clear_job = 1'b1;
                    OP_START: cmd.start_prog = 1'b1;
                    OP_CARD:
                    begin
                        if (stat.card_ok) begin
                            // Read the target word first; the card keeps bytes past its end.
                            cmd.emit   = 1'b0;
                            cmd.rd_en  = 1'b1;
                            cmd.asel   = ASEL_PTR;
                            state_next = S_CARD_WR;
                        end else begin
                            cmd.card_cancel = 1'b1;
                        end
                    end
                    OP_EXEC:
                    begin
                        if (stat.halted) begin
                            cmd.res_status = ST_HALT;
                        end else if (stat.card_pending) begin
                            cmd.res_status = ST_CARD;
                            cmd.res_asel   = RA_PTR;
                        end else if (stat.ic_oob) begin
                            cmd.set_halt   = 1'b1;
                            cmd.res_status = ST_BADADDR;
                        end else begin
                            cmd.emit   = 1'b0;
                            cmd.rd_en  = 1'b1;
                            cmd.asel   = ASEL_IC;
                            cmd.ic_inc = 1'b1;
                            state_next = S_DECODE;
                        end
                    end
                    default: cmd.res_status = ST_OK;
                endcase
            end
            S_CARD_WR:
            begin
                cmd.wr_en        = 1'b1;
                cmd.asel         = ASEL_PTR;
                cmd.wsel         = WSEL_MERGE;
                cmd.card_advance = 1'b1;
                cmd.emit         = 1'b1;
                cmd.res_last     = 1'b1;
                cmd.res_asel     = RA_PTR;
                cmd.res_status   = stat.rem_one ? ST_OK : ST_CARD;
                state_next       = S_IDLE;
            end
            S_DECODE:
            begin
                cmd.emit     = 1'b1;
                cmd.res_last = 1'b1;
                cmd.load_loc = 1'b1;
                state_next   = S_IDLE;
                if (stat.kind == K_H) begin
                    cmd.set_halt   = 1'b1;
                    cmd.res_status = ST_HALT;
                end else if (stat.kind == K_BAD) begin
                    cmd.set_halt   = 1'b1;
                    cmd.res_status = ST_BADOP;
                end else if (stat.addr_err) begin
                    cmd.set_halt   = 1'b1;
                    cmd.res_status = ST_BADADDR;
                end else begin
                    case (stat.kind)
                        K_GD:
                        begin
                            cmd.card_setup = 1'b1;
                            cmd.res_status = ST_CARD;
                            cmd.res_asel   = RA_DEC;
                        end
                        K_PD:
                        begin
                            cmd.emit    = 1'b0;
                            cmd.rd_en   = 1'b1;
                            cmd.asel    = ASEL_DEC;
                            cmd.k_clear = 1'b1;
                            state_next  = S_PD;
                        end
                        K_LR, K_CR:
                        begin
                            cmd.emit   = 1'b0;
                            cmd.rd_en  = 1'b1;
                            cmd.asel   = ASEL_DEC;
                            state_next = (stat.kind == K_LR) ? S_LOAD : S_COMPARE;
                        end
                        K_SR:
                        begin
                            cmd.wr_en = 1'b1;
                            cmd.asel  = ASEL_DEC;
                            cmd.wsel  = WSEL_GR;
                        end
                        K_BT: cmd.ic_jump = stat.flag;
                        default: cmd.res_status = ST_OK;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.load_gr  = 1'b1;
                cmd.emit     = 1'b1;
                cmd.res_last = 1'b1;
                state_next   = S_IDLE;
            end
            S_COMPARE:
            begin
                cmd.compare  = 1'b1;
                cmd.emit     = 1'b1;
                cmd.res_last = 1'b1;
                state_next   = S_IDLE;
            end
            S_PD:
            begin
                // One output word per cycle; the next word is read while this one goes out.
                cmd.emit       = 1'b1;
                cmd.res_status = ST_OUT;
                cmd.res_asel   = RA_LOC_K;
                cmd.res_word   = 1'b1;
                cmd.res_last   = stat.k_last;
                if (stat.k_last) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.rd_en = 1'b1;
                    cmd.asel  = ASEL_LOC_NEXT;
                    cmd.k_inc = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> state_reg == S_DISPATCH)
        else $error("accepted word did not start dispatch");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !cmd.emit && !cmd.wr_en && !cmd.rd_en)
        else $error("memory or result activity while idle");

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd_en && cmd.wr_en))
        else $error("read and write in the same cycle");

endmodule

@@ sv/card_machine_instruction_step.sv @@
`timescale 1ns / 1ps

// Single-step card machine: 100 words of four characters, one register.
// Input: a word is taken at a rising edge with start high and busy low
// (op, address, word_data, byte_count). Busy stays high until the last
// result of that word has been registered.
// Output: each result is on status, out_address, out_word, out_bytes and
// last for exactly one cycle while done is high; last marks the final one.
// The receiver cannot stall, so results are never held back.
// Steps from the accept edge to the final result: write, clear, start,
//   unused op, refused card word, execute that stops early: dispatch
//   only; card word: dispatch, card write; execute of H, GD, SR, BT or a
//   faulty word: dispatch, decode; LR, CR: dispatch, decode, load or
//   compare; PD: dispatch, decode, BLOCK_WORDS words out, one per cycle.
// A new word can be taken in the cycle its final result is shown.
// The steps come from the single-port main memory with a registered read:
// the instruction fetch, the operand read and the card read-modify-write
// each need a step of their own.
// Reset (and a clear job) marks every memory word as unwritten through a
// valid bit per word; such a word reads as four dollar signs, so there is
// no clearing pass and the block is ready right after reset.

module card_machine_instruction_step #(
    parameter int MEM_WORDS   = 100,
    parameter int BLOCK_WORDS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [6:0]  address,
    input  logic [31:0] word_data,
    input  logic [2:0]  byte_count,
    output logic        done,
    output logic [2:0]  status,
    output logic [6:0]  out_address,
    output logic [31:0] out_word,
    output logic [2:0]  out_bytes,
    output logic        last
);
    import cmis_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    cmis_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    cmis_dp #(
        .MEM_WORDS   (MEM_WORDS),
        .BLOCK_WORDS (BLOCK_WORDS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .address     (address),
        .word_data   (word_data),
        .byte_count  (byte_count),
        .cmd         (cmd),
        .stat        (stat),
        .done        (done),
        .status      (status),
        .out_address (out_address),
        .out_word    (out_word),
        .out_bytes   (out_bytes),
        .last        (last)
    );

endmodule
